/* hdl/tsu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// Constants shared by the Taylor sine unit and its checker.
package tsu_pkg;

  // Number of odd Taylor terms summed, and the Horner steps that follow from it.
  localparam int TERM_COUNT = 9;
  localparam int ITER_COUNT = TERM_COUNT - 1;

  // Port widths.
  localparam int ANG_W = 32;
  localparam int OUT_W = 32;

  // Range reduction works on |angle| shifted up into a Q.48 word.
  localparam int RED_W    = 2 * ANG_W;
  // Quotient bits of the reduction: 2^63 / (2*pi in Q.48) stays below 2^13.
  localparam int QUO_BITS = 13;

  // Internal widths: reduced angle, its square, the running Horner value,
  // the scaled product inside a step, and the reciprocal constants.
  localparam int M_W    = 51;
  localparam int Y_W    = 54;
  localparam int T_W    = 52;
  localparam int P_W    = 58;
  localparam int REC_W  = 59;
  localparam int FRAC_W = 48;
  localparam int LIMB_W = 32;

  // Final scaling from Q.48 * Q.48 down to Q.30.
  localparam int RES_SHIFT = 66;
  localparam int V_W       = M_W + T_W - RES_SHIFT;

  localparam logic [M_W-1:0]   TWO_PI_Q48 = 51'h6_487E_D511_0B46;
  localparam logic [T_W-1:0]   ONE_Q48    = 52'h1_0000_0000_0000;
  localparam logic [OUT_W-1:0] SAT_MAX    = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] MOST_NEG   = 32'h8000_0000;

  // Register stages from the input transfer to the result strobe.
  localparam int PIPE_LAT = 1 + QUO_BITS + 2 + 5 * ITER_COUNT + 3;

endpackage
`default_nettype wire

/* hdl/taylor_sine_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Pipelined fixed-point sine: modulo-2*pi reduction followed by a Horner Taylor series.
//
// The unit takes a Q16.16 angle in radians on in_angle and returns its sine in Q2.30 on
// out_sine_value. A transfer happens on every rising edge with start high and busy low; busy
// is high only while rst_n is low and for the cycle after, so in normal operation a new angle
// can be taken every cycle. Each result is shown for exactly one cycle with out_valid high,
// and results leave in transfer order. The receiver has no way to hold results off, so it
// must take every strobe. The delay from a transfer to its result is set by the register
// stages of the data path: one input stage, thirteen restoring-remainder stages
// that reduce |angle| modulo 2*pi (one quotient bit each), two stages for the square, five
// stages for each of the eight Horner steps (partial products, sum, reciprocal partial
// products, sum and shift, update), and three stages for the final product, saturation and
// sign. Every wide product is cut into 32-bit limbs whose partial products are registered
// before they are summed. The division in each Horner step by the constant 2k*(2k+1) is an
// exact multiply by a rounded-up reciprocal, so no divider is needed.
module taylor_sine_unit (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  output logic                              busy,
  input  wire signed [tsu_pkg::ANG_W-1:0]   in_angle,
  output logic                              out_valid,
  output logic signed [tsu_pkg::OUT_W-1:0]  out_sine_value
);

  localparam int AW = tsu_pkg::ANG_W;
  localparam int OW = tsu_pkg::OUT_W;
  localparam int RW = tsu_pkg::RED_W;
  localparam int QB = tsu_pkg::QUO_BITS;
  localparam int MW = tsu_pkg::M_W;
  localparam int YW = tsu_pkg::Y_W;
  localparam int TW = tsu_pkg::T_W;
  localparam int PW = tsu_pkg::P_W;
  localparam int CW = tsu_pkg::REC_W;
  localparam int LW = tsu_pkg::LIMB_W;
  localparam int FW = tsu_pkg::FRAC_W;
  localparam int VW = tsu_pkg::V_W;
  localparam int IT = tsu_pkg::ITER_COUNT;
  localparam int TC = tsu_pkg::TERM_COUNT;
  // Width of the product of a scaled value and its reciprocal.
  localparam int WW = 4 * LW;

  // Square of the reduced angle, as registered partial products.
  typedef struct packed {
    logic                   neg;
    logic [MW-1:0]          m;
    logic [2*LW-1:0]        ll;
    logic [MW-1:0]          lh;
    logic [2*(MW-LW)-1:0]   hh;
  } sq_t;

  // Values passed from one Horner step to the next.
  typedef struct packed {
    logic           neg;
    logic           t_neg;
    logic [MW-1:0]  m;
    logic [YW-1:0]  y;
    logic [TW-1:0]  t_mag;
  } iter_t;

  // Partial products of t * y.
  typedef struct packed {
    logic                     neg;
    logic                     t_neg;
    logic [MW-1:0]            m;
    logic [YW-1:0]            y;
    logic [2*LW-1:0]          ll;
    logic [YW-1:0]            lh;
    logic [TW-1:0]            hl;
    logic [TW+YW-2*LW-1:0]    hh;
  } ty_t;

  // Scaled product p, or quotient q, with the values carried alongside.
  typedef struct packed {
    logic           neg;
    logic           t_neg;
    logic [MW-1:0]  m;
    logic [YW-1:0]  y;
    logic [PW-1:0]  val;
  } pq_t;

  // Partial products of p * reciprocal.
  typedef struct packed {
    logic                     neg;
    logic                     t_neg;
    logic [MW-1:0]            m;
    logic [YW-1:0]            y;
    logic [2*LW-1:0]          ll;
    logic [CW-1:0]            lh;
    logic [PW-1:0]            hl;
    logic [PW+CW-2*LW-1:0]    hh;
  } pr_t;

  // Partial products of m * t for the result.
  typedef struct packed {
    logic                     out_neg;
    logic [2*LW-1:0]          ll;
    logic [TW-1:0]            lh;
    logic [MW-1:0]            hl;
    logic [MW+TW-2*LW-1:0]    hh;
  } fin_t;

  // Saturated magnitude and sign of the result.
  typedef struct packed {
    logic           out_neg;
    logic [OW-2:0]  mag;
  } sat_t;

  // ---------------------------------------------------------------------------------------
  // Handshake. The pipeline never stalls, so busy only covers reset.
  // ---------------------------------------------------------------------------------------
  logic rdy_r;
  logic in_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdy_r <= 1'b0;
    end else begin
      rdy_r <= 1'b1;
    end
  end

  assign busy    = !rdy_r || !rst_n;
  assign in_fire = start && !busy;

  // ---------------------------------------------------------------------------------------
  // Input stage: take the magnitude of the angle and place it in Q.48.
  // The most negative angle has magnitude 2^31, which still fits the unsigned word.
  // ---------------------------------------------------------------------------------------
  logic [RW-1:0] red_r     [0:QB];
  logic          red_neg_r [0:QB];
  logic          red_vld_r [0:QB];

  logic [AW-1:0] ang_u;
  logic [AW-1:0] in_mag_nxt;

  assign ang_u = in_angle;

  always_comb begin
    if (ang_u[AW-1]) begin
      in_mag_nxt = {AW{1'b0}} - ang_u;
    end else begin
      in_mag_nxt = ang_u;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_vld_r[0] <= 1'b0;
    end else begin
      red_vld_r[0] <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    red_r[0]     <= {in_mag_nxt, {AW{1'b0}}};
    red_neg_r[0] <= ang_u[AW-1];
  end

  // ---------------------------------------------------------------------------------------
  // Range reduction: restoring remainder against 2*pi, one quotient bit per stage,
  // from the highest shift down to zero.
  // ---------------------------------------------------------------------------------------
  for (genvar j = 0; j < QB; j++) begin : g_red
    localparam int SH = QB - 1 - j;
    localparam logic [RW-1:0] DSH = RW'(tsu_pkg::TWO_PI_Q48) << SH;

    logic [RW-1:0] red_nxt;

    always_comb begin
      if (red_r[j] >= DSH) begin
        red_nxt = red_r[j] - DSH;
      end else begin
        red_nxt = red_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        red_vld_r[j+1] <= 1'b0;
      end else begin
        red_vld_r[j+1] <= red_vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      red_r[j+1]     <= red_nxt;
      red_neg_r[j+1] <= red_neg_r[j];
    end
  end

  // ---------------------------------------------------------------------------------------
  // Square of the reduced angle m, split into a 32-bit low limb and a narrow high limb.
  // The two cross products are equal, so one is computed and doubled in the sum.
  // ---------------------------------------------------------------------------------------
  logic [MW-1:0] m_red;
  sq_t           sq_nxt;
  sq_t           sq_r;
  logic          sq_vld_r;

  assign m_red = red_r[QB][MW-1:0];

  always_comb begin
    sq_nxt.neg = red_neg_r[QB];
    sq_nxt.m   = m_red;
    sq_nxt.ll  = (2*LW)'(m_red[LW-1:0]) * (2*LW)'(m_red[LW-1:0]);
    sq_nxt.lh  = MW'(m_red[LW-1:0]) * MW'(m_red[MW-1:LW]);
    sq_nxt.hh  = (2*(MW-LW))'(m_red[MW-1:LW]) * (2*(MW-LW))'(m_red[MW-1:LW]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
    end else begin
      sq_vld_r <= red_vld_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    sq_r <= sq_nxt;
  end

  // The sum of the square stage seeds the first Horner step with t = 1.0.
  iter_t         it_r     [0:IT];
  logic          it_vld_r [0:IT];
  iter_t         it0_nxt;
  logic [2*MW-1:0] sq_full;

  always_comb begin
    sq_full = (2*MW)'(sq_r.ll)
            + ((2*MW)'(sq_r.lh) << (LW + 1))
            + ((2*MW)'(sq_r.hh) << (2 * LW));
    it0_nxt.neg   = sq_r.neg;
    it0_nxt.t_neg = 1'b0;
    it0_nxt.m     = sq_r.m;
    it0_nxt.y     = sq_full[FW +: YW];
    it0_nxt.t_mag = tsu_pkg::ONE_Q48;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_vld_r[0] <= 1'b0;
    end else begin
      it_vld_r[0] <= sq_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    it_r[0] <= it0_nxt;
  end

  // ---------------------------------------------------------------------------------------
  // Horner steps, from the highest term down: q = ((t * y) >> 48) / (2k*(2k+1)), then
  // t = 1 - sign(t) * q. The division multiplies by R = ceil(2^S / d) with
  // S = P_W + clog2(d), which gives the exact truncated quotient for any p below 2^P_W.
  // ---------------------------------------------------------------------------------------
  ty_t  a_r     [0:IT-1];
  logic a_vld_r [0:IT-1];
  pq_t  b_r     [0:IT-1];
  logic b_vld_r [0:IT-1];
  pr_t  c_r     [0:IT-1];
  logic c_vld_r [0:IT-1];
  pq_t  d_r     [0:IT-1];
  logic d_vld_r [0:IT-1];

  for (genvar it = 0; it < IT; it++) begin : g_horner
    localparam int KK    = TC - 1 - it;
    localparam int DIV   = 2 * KK * (2 * KK + 1);
    localparam int SHIFT = PW + $clog2(DIV);
    localparam logic [WW-1:0] RECIP_WIDE = ((WW'(1) << SHIFT) + WW'(DIV - 1)) / WW'(DIV);
    localparam logic [CW-1:0]    RECIP  = RECIP_WIDE[CW-1:0];
    localparam logic [LW-1:0]    REC_LO = RECIP[LW-1:0];
    localparam logic [CW-LW-1:0] REC_HI = RECIP[CW-1:LW];

    ty_t              a_nxt;
    pq_t              b_nxt;
    pr_t              c_nxt;
    pq_t              d_nxt;
    iter_t            e_nxt;
    logic [TW+YW-1:0] ty_full;
    logic [WW-1:0]    pr_full;
    logic [PW-1:0]    q;

    // Partial products of t * y.
    always_comb begin
      a_nxt.neg   = it_r[it].neg;
      a_nxt.t_neg = it_r[it].t_neg;
      a_nxt.m     = it_r[it].m;
      a_nxt.y     = it_r[it].y;
      a_nxt.ll    = (2*LW)'(it_r[it].t_mag[LW-1:0]) * (2*LW)'(it_r[it].y[LW-1:0]);
      a_nxt.lh    = YW'(it_r[it].t_mag[LW-1:0]) * YW'(it_r[it].y[YW-1:LW]);
      a_nxt.hl    = TW'(it_r[it].t_mag[TW-1:LW]) * TW'(it_r[it].y[LW-1:0]);
      a_nxt.hh    = (TW+YW-2*LW)'(it_r[it].t_mag[TW-1:LW])
                  * (TW+YW-2*LW)'(it_r[it].y[YW-1:LW]);
    end

    // Sum and drop the 48 fraction bits.
    always_comb begin
      ty_full = (TW+YW)'(a_r[it].ll)
              + ((TW+YW)'(a_r[it].lh) << LW)
              + ((TW+YW)'(a_r[it].hl) << LW)
              + ((TW+YW)'(a_r[it].hh) << (2 * LW));
      b_nxt.neg   = a_r[it].neg;
      b_nxt.t_neg = a_r[it].t_neg;
      b_nxt.m     = a_r[it].m;
      b_nxt.y     = a_r[it].y;
      b_nxt.val   = ty_full[FW +: PW];
    end

    // Partial products of p * R.
    always_comb begin
      c_nxt.neg   = b_r[it].neg;
      c_nxt.t_neg = b_r[it].t_neg;
      c_nxt.m     = b_r[it].m;
      c_nxt.y     = b_r[it].y;
      c_nxt.ll    = (2*LW)'(b_r[it].val[LW-1:0]) * (2*LW)'(REC_LO);
      c_nxt.lh    = CW'(b_r[it].val[LW-1:0]) * CW'(REC_HI);
      c_nxt.hl    = PW'(b_r[it].val[PW-1:LW]) * PW'(REC_LO);
      c_nxt.hh    = (PW+CW-2*LW)'(b_r[it].val[PW-1:LW]) * (PW+CW-2*LW)'(REC_HI);
    end

    // Sum and shift down by S to get the quotient.
    always_comb begin
      pr_full = WW'(c_r[it].ll)
              + (WW'(c_r[it].lh) << LW)
              + (WW'(c_r[it].hl) << LW)
              + (WW'(c_r[it].hh) << (2 * LW));
      d_nxt.neg   = c_r[it].neg;
      d_nxt.t_neg = c_r[it].t_neg;
      d_nxt.m     = c_r[it].m;
      d_nxt.y     = c_r[it].y;
      d_nxt.val   = pr_full[SHIFT +: PW];
    end

    // Update t in sign-magnitude form.
    always_comb begin
      q           = d_r[it].val;
      e_nxt.neg   = d_r[it].neg;
      e_nxt.m     = d_r[it].m;
      e_nxt.y     = d_r[it].y;
      if (d_r[it].t_neg) begin
        e_nxt.t_mag = tsu_pkg::ONE_Q48 + TW'(q);
        e_nxt.t_neg = 1'b0;
      end else if (q > PW'(tsu_pkg::ONE_Q48)) begin
        e_nxt.t_mag = TW'(q - PW'(tsu_pkg::ONE_Q48));
        e_nxt.t_neg = 1'b1;
      end else begin
        e_nxt.t_mag = TW'(PW'(tsu_pkg::ONE_Q48) - q);
        e_nxt.t_neg = 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_vld_r[it]    <= 1'b0;
        b_vld_r[it]    <= 1'b0;
        c_vld_r[it]    <= 1'b0;
        d_vld_r[it]    <= 1'b0;
        it_vld_r[it+1] <= 1'b0;
      end else begin
        a_vld_r[it]    <= it_vld_r[it];
        b_vld_r[it]    <= a_vld_r[it];
        c_vld_r[it]    <= b_vld_r[it];
        d_vld_r[it]    <= c_vld_r[it];
        it_vld_r[it+1] <= d_vld_r[it];
      end
    end

    always_ff @(posedge clk) begin
      a_r[it]    <= a_nxt;
      b_r[it]    <= b_nxt;
      c_r[it]    <= c_nxt;
      d_r[it]    <= d_nxt;
      it_r[it+1] <= e_nxt;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result: v = (m * |t|) >> 66, saturated to 31 bits, then the combined sign applied.
  // A negative result is never the most negative code, since the magnitude is capped.
  // ---------------------------------------------------------------------------------------
  fin_t              fin_nxt;
  fin_t              fin_r;
  logic              fin_vld_r;
  sat_t              sat_nxt;
  sat_t              sat_r;
  logic              sat_vld_r;
  logic [MW+TW-1:0]  res_full;
  logic [VW-1:0]     res_v;
  logic [OW-1:0]     res_mag;
  logic [OW-1:0]     out_val_nxt;
  logic [OW-1:0]     out_val_r;
  logic              out_valid_r;

  always_comb begin
    fin_nxt.out_neg = it_r[IT].neg ^ it_r[IT].t_neg;
    fin_nxt.ll      = (2*LW)'(it_r[IT].m[LW-1:0]) * (2*LW)'(it_r[IT].t_mag[LW-1:0]);
    fin_nxt.lh      = TW'(it_r[IT].m[LW-1:0]) * TW'(it_r[IT].t_mag[TW-1:LW]);
    fin_nxt.hl      = MW'(it_r[IT].m[MW-1:LW]) * MW'(it_r[IT].t_mag[LW-1:0]);
    fin_nxt.hh      = (MW+TW-2*LW)'(it_r[IT].m[MW-1:LW])
                    * (MW+TW-2*LW)'(it_r[IT].t_mag[TW-1:LW]);
  end

  always_comb begin
    res_full = (MW+TW)'(fin_r.ll)
             + ((MW+TW)'(fin_r.lh) << LW)
             + ((MW+TW)'(fin_r.hl) << LW)
             + ((MW+TW)'(fin_r.hh) << (2 * LW));
    res_v           = res_full[tsu_pkg::RES_SHIFT +: VW];
    sat_nxt.out_neg = fin_r.out_neg;
    if (|res_v[VW-1:OW-1]) begin
      sat_nxt.mag = tsu_pkg::SAT_MAX[OW-2:0];
    end else begin
      sat_nxt.mag = res_v[OW-2:0];
    end
  end

  always_comb begin
    res_mag = {1'b0, sat_r.mag};
    if (sat_r.out_neg) begin
      out_val_nxt = {OW{1'b0}} - res_mag;
    end else begin
      out_val_nxt = res_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r   <= 1'b0;
      sat_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fin_vld_r   <= it_vld_r[IT];
      sat_vld_r   <= fin_vld_r;
      out_valid_r <= sat_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    fin_r     <= fin_nxt;
    sat_r     <= sat_nxt;
    out_val_r <= out_val_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sine_value = out_val_r;

endmodule
`default_nettype wire

/* hdl/tsu_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// Port-level checker for the Taylor sine unit, bound to its top level.
module tsu_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              start,
  input wire                              busy,
  input wire signed [tsu_pkg::ANG_W-1:0]  in_angle,
  input wire                              out_valid,
  input wire signed [tsu_pkg::OUT_W-1:0]  out_sine_value
);

  localparam int LAT = tsu_pkg::PIPE_LAT;

  logic in_fire;

  assign in_fire = start && !busy;

  // Every transfer yields a strobe after the fixed latency.
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ##LAT out_valid)
    else $error("no result strobe after an input transfer");

  // No strobe appears without a transfer the fixed latency earlier.
  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_fire, LAT))
    else $error("result strobe without a matching input transfer");

  // A zero angle gives a zero sine.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(in_angle, LAT) == '0)) |-> (out_sine_value == '0))
    else $error("nonzero sine for a zero angle");

  // Saturation keeps the result away from the most negative code.
  a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sine_value != tsu_pkg::MOST_NEG))
    else $error("result equals the most negative code");

endmodule

bind taylor_sine_unit tsu_checker u_tsu_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_angle       (in_angle),
  .out_valid      (out_valid),
  .out_sine_value (out_sine_value)
);
`default_nettype wire
